// ===== hdl/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// Taylor shift package
// Shared widths, item types, state encoding and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

    localparam int MAX_DEGREE  = 15;
    localparam int COEF_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int STORE_DEPTH = MAX_DEGREE + 1;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int PROD_W      = 2 * COEF_WIDTH;
    localparam int TERM_W      = 4;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;
    localparam int REG_IDX_W   = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_SHIFT_POINT = REG_IDX_W'(0);

    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    typedef struct packed {
        coef_t coefficient;
        logic  last_coefficient;
    } in_item_t;

    typedef struct packed {
        coef_t             taylor_coefficient;
        logic [TERM_W-1:0] term_index;
        logic              last_term;
        logic              overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MUL,
        S_ABS,
        S_RND,
        S_ADD,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic abs_en;
        logic rnd_en;
    } dp_ctrl_t;

    typedef struct packed {
        logic rnd_sat;
        logic add_sat;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/tps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/tps_dp.sv =====
// ----------------------------------------------------------------------------
// Taylor shift multiply-add datapath
// a * carry, round to nearest (ties away from zero), saturate, then
// saturating add of the stored coefficient. Three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tps_dp
    import tps_pkg::*;
(
    input  wire logic     clk,
    input  wire dp_ctrl_t ctrl,
    input  wire coef_t    shift_point,
    input  wire coef_t    carry,
    input  wire coef_t    bval,
    output coef_t         sum,
    output dp_stat_t      stat
);

    localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] POS_LIM  = (PROD_W'(1) << (COEF_WIDTH - 1)) - PROD_W'(1);
    localparam logic [PROD_W-1:0] NEG_LIM  = PROD_W'(1) << (COEF_WIDTH - 1);
    localparam coef_t COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam coef_t COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0]        mag_reg;
    logic                     neg_reg;
    coef_t                    prodr_reg;

    logic [PROD_W-1:0]        q;
    logic                     rnd_sat;
    coef_t                    prodr_next;
    logic [COEF_WIDTH:0]      wide_sum;
    logic                     add_sat;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(shift_point) * PROD_W'(carry);
        end
        if (ctrl.abs_en)
        begin
            neg_reg <= prod_reg[PROD_W-1];
            mag_reg <= (prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg))
                       + HALF_LSB;
        end
        if (ctrl.rnd_en)
        begin
            prodr_reg <= prodr_next;
        end
    end

    always_comb
    begin
        q       = mag_reg >> FRAC_BITS;
        rnd_sat = q > (neg_reg ? NEG_LIM : POS_LIM);
        if (rnd_sat)
        begin
            prodr_next = neg_reg ? COEF_MIN : COEF_MAX;
        end
        else
        begin
            prodr_next = neg_reg ? coef_t'(-q[COEF_WIDTH-1:0]) : coef_t'(q[COEF_WIDTH-1:0]);
        end
    end

    always_comb
    begin
        wide_sum = {bval[COEF_WIDTH-1], bval} + {prodr_reg[COEF_WIDTH-1], prodr_reg};
        add_sat  = wide_sum[COEF_WIDTH] != wide_sum[COEF_WIDTH-1];
        if (add_sat)
        begin
            sum = wide_sum[COEF_WIDTH] ? COEF_MIN : COEF_MAX;
        end
        else
        begin
            sum = wide_sum[COEF_WIDTH-1:0];
        end
    end

    assign stat.rnd_sat = ctrl.rnd_en & rnd_sat;
    assign stat.add_sat = add_sat;

endmodule

`default_nettype wire

// ===== hdl/taylor_polynomial_shift_core.sv =====
// ----------------------------------------------------------------------------
// Taylor polynomial shift core
// Loads polynomial coefficients and emits the Taylor coefficients about a.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): one coefficient per item, lowest
// power first; last_coefficient closes the polynomial. Items past
// MAX_DEGREE+1 are dropped and flag overflow. shift_point is written over the
// APB port at address 0; the user must write it only while idle, and the
// block does not enforce this. After the closing item the block trims zero
// top terms to degree d and runs repeated synthetic division in place in the
// coefficient RAM: d*(d+1)/2 multiply-adds (multiply, magnitude,
// round/saturate, add and write back), run in series, set by the serial carry
// through the single multiplier. Results then leave one at a time, k = 0 to d,
// via a RAM read (S_EMIT_RD) and an output register load (S_EMIT_LD).
// in_stall is high from the closing item until the last result sits in the
// output register; the next polynomial may load while it waits there. If the
// receiver stalls, emission holds with the current result in place.
// Reset clears the loader, the run state and shift_point; the RAM needs no
// clearing since every entry read in a run was written in that run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module taylor_polynomial_shift_core
    import tps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_item_t              out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              excess_reg, excess_next;
    logic [IDX_W-1:0]  top_idx_reg, top_idx_next;
    coef_t             top_val_reg, top_val_next;
    logic [IDX_W-1:0]  d_reg, d_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    coef_t             carry_reg, carry_next;
    logic              ovf_reg, ovf_next;
    coef_t             shift_point_reg, shift_point_next;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic              in_acc;
    logic              room;
    logic              keep_top;
    logic [IDX_W-1:0]  d_run;
    logic              out_free;
    logic              out_load;
    logic              pass_done;
    logic              last_pass;
    logic              cfg_wr;
    logic              reg_hit;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    coef_t             ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [COEF_WIDTH-1:0] ram_rdata;

    dp_ctrl_t          dp_ctrl;
    dp_stat_t          dp_stat;
    coef_t             dp_sum;

    tps_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tps_dp u_dp (
        .clk         (clk),
        .ctrl        (dp_ctrl),
        .shift_point (shift_point_reg),
        .carry       (carry_reg),
        .bval        (coef_t'(ram_rdata)),
        .sum         (dp_sum),
        .stat        (dp_stat)
    );

    assign in_stall  = (state_reg != S_LOAD);
    assign in_acc    = in_valid & ~in_stall;
    assign room      = cnt_reg < CNT_W'(STORE_DEPTH);
    assign keep_top  = room & (in_data.coefficient != '0);
    assign d_run     = keep_top ? cnt_reg[IDX_W-1:0] : top_idx_reg;
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign pass_done = (i_reg == k_reg);
    assign last_pass = (k_reg == d_reg - IDX_W'(1));

    // APB register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1:2] == REG_SHIFT_POINT);
    assign cfg_wr  = psel & penable & pwrite;
    assign prdata  = reg_hit ? APB_DW'(unsigned'(shift_point_reg)) : '0;

    always_comb
    begin
        shift_point_next = shift_point_reg;
        if (cfg_wr && reg_hit)
        begin
            shift_point_next = coef_t'(pwdata[COEF_WIDTH-1:0]);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc && in_data.last_coefficient)
                begin
                    state_next = (d_run == '0) ? S_EMIT_RD : S_MUL;
                end
            end
            S_MUL:     state_next = S_ABS;
            S_ABS:     state_next = S_RND;
            S_RND:     state_next = S_ADD;
            S_ADD:
            begin
                state_next = (pass_done && last_pass) ? S_EMIT_RD : S_MUL;
            end
            S_EMIT_RD: state_next = S_EMIT_LD;
            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = (k_reg == d_reg) ? S_LOAD : S_EMIT_RD;
                end
            end
            default:   state_next = S_LOAD;
        endcase
    end

    // outputs and run registers
    always_comb
    begin
        cnt_next     = cnt_reg;
        excess_next  = excess_reg;
        top_idx_next = top_idx_reg;
        top_val_next = top_val_reg;
        d_next       = d_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        carry_next   = carry_reg;
        ovf_next     = ovf_reg;
        ram_we       = 1'b0;
        ram_waddr    = i_reg;
        ram_wdata    = dp_sum;
        ram_re       = 1'b0;
        ram_raddr    = i_reg;
        dp_ctrl      = '0;
        out_load     = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (room)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[IDX_W-1:0];
                        ram_wdata = in_data.coefficient;
                        cnt_next  = cnt_reg + CNT_W'(1);
                        if (keep_top)
                        begin
                            top_idx_next = cnt_reg[IDX_W-1:0];
                            top_val_next = in_data.coefficient;
                        end
                    end
                    else
                    begin
                        excess_next = 1'b1;
                    end
                    if (in_data.last_coefficient)
                    begin
                        d_next     = d_run;
                        k_next     = '0;
                        i_next     = d_run - IDX_W'(1);
                        carry_next = keep_top ? in_data.coefficient : top_val_reg;
                        ovf_next   = excess_reg | ~room;
                    end
                end
            end
            S_MUL:
            begin
                dp_ctrl.mul_en = 1'b1;
                ram_re         = 1'b1;
            end
            S_ABS:
            begin
                dp_ctrl.abs_en = 1'b1;
            end
            S_RND:
            begin
                dp_ctrl.rnd_en = 1'b1;
                if (dp_stat.rnd_sat)
                begin
                    ovf_next = 1'b1;
                end
            end
            S_ADD:
            begin
                ram_we     = 1'b1;
                carry_next = dp_sum;
                if (dp_stat.add_sat)
                begin
                    ovf_next = 1'b1;
                end
                if (pass_done)
                begin
                    // next pass restarts from the top coefficient
                    k_next     = last_pass ? '0 : k_reg + IDX_W'(1);
                    i_next     = d_reg - IDX_W'(1);
                    carry_next = top_val_reg;
                end
                else
                begin
                    i_next = i_reg - IDX_W'(1);
                end
            end
            S_EMIT_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = k_reg;
            end
            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (k_reg == d_reg)
                    begin
                        cnt_next     = '0;
                        excess_next  = 1'b0;
                        top_idx_next = '0;
                        top_val_next = '0;
                    end
                    else
                    begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            cnt_reg         <= '0;
            excess_reg      <= 1'b0;
            top_idx_reg     <= '0;
            top_val_reg     <= '0;
            d_reg           <= '0;
            k_reg           <= '0;
            i_reg           <= '0;
            ovf_reg         <= 1'b0;
            shift_point_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            excess_reg      <= excess_next;
            top_idx_reg     <= top_idx_next;
            top_val_reg     <= top_val_next;
            d_reg           <= d_next;
            k_reg           <= k_next;
            i_reg           <= i_next;
            ovf_reg         <= ovf_next;
            shift_point_reg <= shift_point_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (out_load)
        begin
            out_data_reg.taylor_coefficient <= coef_t'(ram_rdata);
            out_data_reg.term_index         <= TERM_W'(k_reg);
            out_data_reg.last_term          <= (k_reg == d_reg);
            out_data_reg.overflow           <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/tps_checker.sv =====
// ----------------------------------------------------------------------------
// Taylor shift port checker
// Run ordering and handshake checks on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tps_checker
    import tps_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire in_item_t          in_data,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire out_item_t         out_data
);

    logic              in_acc;
    logic              out_acc;
    logic              exp_valid_reg;
    logic [TERM_W-1:0] exp_idx_reg;
    logic              exp_ovf_reg;

    assign in_acc  = in_valid & ~in_stall;
    assign out_acc = out_valid & ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_valid_reg <= 1'b0;
            exp_idx_reg   <= '0;
            exp_ovf_reg   <= 1'b0;
        end
        else if (out_acc)
        begin
            exp_valid_reg <= ~out_data.last_term;
            exp_idx_reg   <= out_data.term_index + TERM_W'(1);
            exp_ovf_reg   <= out_data.overflow;
        end
    end

    // results of one run count up from zero
    a_term_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && exp_valid_reg |-> out_data.term_index == exp_idx_reg)
        else $error("term_index out of sequence");

    a_term_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !exp_valid_reg |-> out_data.term_index == '0)
        else $error("run does not start at term 0");

    a_ovf_const: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && exp_valid_reg |-> out_data.overflow == exp_ovf_reg)
        else $error("overflow changed within a run");

    a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_data.last_coefficient |=> in_stall)
        else $error("input taken right after closing item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result dropped or changed");

endmodule

bind taylor_polynomial_shift_core tps_checker u_tps_checker (.*);

`default_nettype wire
